FILE: sv/periodic_event_scheduler_defines.svh
// Assertion macros used by the checker of the event scheduler.
// Depends on nothing; include by bare file name.
`ifndef PERIODIC_EVENT_SCHEDULER_DEFINES_SVH
`define PERIODIC_EVENT_SCHEDULER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PES_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/pes_pkg.sv
// Types, constants and helpers of the periodic event scheduler.
// No dependencies; used by the top level and the checker.
`default_nettype none
package pes_pkg;

   localparam int NUM_EVENTS  = 8;
   localparam int IDX_W       = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
   localparam int CNT_W       = $clog2(NUM_EVENTS + 1);
   localparam int MAX_FIRINGS = 8;
   localparam int FIRE_W      = $clog2(MAX_FIRINGS + 1);

   localparam logic [31:0] MAX_STEP_RESET = 32'd10000;
   localparam logic [31:0] DUE_TIME_MAX   = 32'hFFFF_FFFF;

   localparam logic [2:0] FUNC_TICK     = 3'd0;
   localparam logic [2:0] FUNC_REGISTER = 3'd1;
   localparam logic [2:0] FUNC_FORCE    = 3'd2;
   localparam logic [2:0] FUNC_SYNC     = 3'd3;
   localparam logic [2:0] FUNC_SET_INTV = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] new_time;
      logic [7:0]  event_id;
      logic [31:0] interval;
      logic [31:0] offset;
   } req_type;

   typedef struct packed {
      logic        fired;
      logic [7:0]  fired_id;
      logic [2:0]  slot_index;
      logic [31:0] elapsed_time;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [31:0] period;
      logic [31:0] start_delay;
      logic [31:0] due;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic rsp_type make_status(logic [IDX_W-1:0] slot, logic [31:0] elapsed,
                                           logic [1:0] status);
      rsp_type r;
      r.fired        = 1'b0;
      r.fired_id     = 8'd0;
      r.slot_index   = 3'(slot);
      r.elapsed_time = elapsed;
      r.status       = status;
      r.last         = 1'b1;
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: sv/periodic_event_scheduler.sv
// Periodic event scheduler. The event table (id, period, start delay, due
// time) lives in one synchronous RAM that a sequencer walks one slot per
// cycle. Register items and unused function codes need no table walk.
// Force, set-interval and sync take one table walk. A tick takes one walk
// to find the soonest event plus one more walk per firing (at most 8
// firings). Results leave through an output register, so downstream
// stall only stretches the time spent waiting to emit. Inputs are taken
// one at a time, only while the sequencer is idle and the output register
// can take a result. max_step may be written at any idle time; csr_ready
// stays high. No clearing pass is needed after reset.
`default_nettype none
module periodic_event_scheduler (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire pes_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output pes_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [31:0]      csr_data
);
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   pes_pkg::req_type           req_ff, req_in;
   logic [pes_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [pes_pkg::CNT_W-1:0]  used_ff, used_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [pes_pkg::IDX_W-1:0]  rd_slot_ff, rd_slot_in;
   logic [pes_pkg::IDX_W-1:0]  best_slot_ff, best_slot_in;
   pes_pkg::entry_type         best_ff, best_in;
   logic                       found_ff, found_in;
   logic [pes_pkg::FIRE_W-1:0] fires_ff, fires_in;
   logic                       pend_valid_ff, pend_valid_in;
   pes_pkg::rsp_type           pend_ff, pend_in;
   logic [31:0]                elapsed_ff, elapsed_in;
   logic [31:0]                prev_raw_ff, prev_raw_in;
   logic                       raw_seen_ff, raw_seen_in;
   logic [31:0]                max_step_ff;
   logic                       rsp_valid_ff;
   pes_pkg::rsp_type           rsp_data_ff;

   // output register side
   logic             out_free;
   logic             emit;
   pes_pkg::rsp_type emit_data;

   // RAM ports
   logic                      wr_en, rd_en;
   logic [pes_pkg::IDX_W-1:0] wr_addr, rd_addr;
   pes_pkg::entry_type        wr_data, rd_data;

   logic        accept;
   logic [31:0] diff;
   logic        do_fire;
   pes_pkg::rsp_type fire_rsp;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign diff      = req_data.new_time - prev_raw_ff;

   pes_ram #(
      .WIDTH(pes_pkg::ENTRY_W),
      .DEPTH(pes_pkg::NUM_EVENTS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Firing result for the soonest entry found by the last walk.
   always_comb begin
      fire_rsp.fired        = 1'b1;
      fire_rsp.fired_id     = best_ff.id;
      fire_rsp.slot_index   = 3'(best_slot_ff);
      fire_rsp.elapsed_time = elapsed_ff;
      fire_rsp.status       = pes_pkg::STATUS_OK;
      fire_rsp.last         = 1'b0;
   end

   assign do_fire = (used_ff != '0) &&
                    (fires_ff != pes_pkg::FIRE_W'(pes_pkg::MAX_FIRINGS)) &&
                    (elapsed_ff >= best_ff.due);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      cnt_in        = cnt_ff;
      used_in       = used_ff;
      rd_vld_in     = 1'b0;
      rd_slot_in    = rd_slot_ff;
      best_slot_in  = best_slot_ff;
      best_in       = best_ff;
      found_in      = found_ff;
      fires_in      = fires_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      elapsed_in    = elapsed_ff;
      prev_raw_in   = prev_raw_ff;
      raw_seen_in   = raw_seen_ff;
      emit          = 1'b0;
      emit_data     = pend_ff;
      wr_en         = 1'b0;
      wr_addr       = best_slot_ff;
      wr_data       = best_ff;
      rd_en         = 1'b0;
      rd_addr       = cnt_ff[pes_pkg::IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in       = req_data;
               cnt_in       = '0;
               found_in     = 1'b0;
               best_slot_in = '0;
               case (req_data.func)
                  pes_pkg::FUNC_TICK: begin
                     // latch the raw time; add the step only after the first tick and only below max_step
                     raw_seen_in = 1'b1;
                     prev_raw_in = req_data.new_time;
                     if (raw_seen_ff && (diff < max_step_ff)) begin
                        elapsed_in = elapsed_ff + diff;
                     end
                     fires_in      = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_SCAN;
                  end
                  pes_pkg::FUNC_REGISTER: begin
                     emit = 1'b1;
                     if (used_ff >= pes_pkg::CNT_W'(pes_pkg::NUM_EVENTS)) begin
                        emit_data = pes_pkg::make_status('0, elapsed_ff,
                                                         pes_pkg::STATUS_FULL);
                     end else begin
                        // fresh entry is due at once until a sync or force
                        wr_en               = 1'b1;
                        wr_addr             = used_ff[pes_pkg::IDX_W-1:0];
                        wr_data.id          = req_data.event_id;
                        wr_data.period      = req_data.interval;
                        wr_data.start_delay = req_data.offset;
                        wr_data.due         = 32'd0;
                        used_in             = used_ff + 1'b1;
                        emit_data = pes_pkg::make_status(used_ff[pes_pkg::IDX_W-1:0],
                                                         elapsed_ff, pes_pkg::STATUS_OK);
                     end
                  end
                  pes_pkg::FUNC_FORCE, pes_pkg::FUNC_SYNC, pes_pkg::FUNC_SET_INTV: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     // unused codes: drop silently
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // issue one read per cycle; data returns in the next cycle
            if (cnt_ff < used_ff) begin
               rd_en      = 1'b1;
               rd_vld_in  = 1'b1;
               rd_slot_in = cnt_ff[pes_pkg::IDX_W-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               case (req_ff.func)
                  pes_pkg::FUNC_TICK: begin
                     // strictly earlier wins, so ties keep the lowest slot
                     if ((rd_slot_ff == '0) || (rd_data.due < best_ff.due)) begin
                        best_in      = rd_data;
                        best_slot_in = rd_slot_ff;
                     end
                  end
                  pes_pkg::FUNC_SYNC: begin
                     // read slot and write back the previous one: never the same entry
                     wr_en       = 1'b1;
                     wr_addr     = rd_slot_ff;
                     wr_data     = rd_data;
                     wr_data.due = elapsed_ff + rd_data.start_delay + rd_data.period;
                  end
                  default: begin
                     if (!found_ff && (rd_data.id == req_ff.event_id)) begin
                        found_in     = 1'b1;
                        best_in      = rd_data;
                        best_slot_in = rd_slot_ff;
                     end
                  end
               endcase
            end else if (cnt_ff == used_ff) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            case (req_ff.func)
               pes_pkg::FUNC_TICK: begin
                  if (do_fire) begin
                     // a queued firing goes out once a later one is known, or with last set at the end
                     if (!pend_valid_ff || out_free) begin
                        emit          = pend_valid_ff;
                        emit_data     = pend_ff;
                        wr_en         = 1'b1;
                        wr_data.due   = elapsed_ff + best_ff.period;
                        pend_valid_in = 1'b1;
                        pend_in       = fire_rsp;
                        fires_in      = fires_ff + 1'b1;
                        cnt_in        = '0;
                        best_slot_in  = '0;
                        state_in      = ST_SCAN;
                     end
                  end else if (pend_valid_ff) begin
                     if (out_free) begin
                        emit           = 1'b1;
                        emit_data      = pend_ff;
                        emit_data.last = 1'b1;
                        pend_valid_in  = 1'b0;
                        state_in       = ST_IDLE;
                     end
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               pes_pkg::FUNC_SYNC: begin
                  if (out_free) begin
                     emit      = 1'b1;
                     emit_data = pes_pkg::make_status('0, elapsed_ff, pes_pkg::STATUS_OK);
                     state_in  = ST_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                     if (found_ff) begin
                        wr_en = 1'b1;
                        if (req_ff.func == pes_pkg::FUNC_FORCE) begin
                           wr_data.due = elapsed_ff + req_ff.offset;
                        end else begin
                           wr_data.period = req_ff.interval;
                        end
                        emit_data = pes_pkg::make_status(best_slot_ff, elapsed_ff,
                                                         pes_pkg::STATUS_OK);
                     end else begin
                        emit_data = pes_pkg::make_status('0, elapsed_ff,
                                                         pes_pkg::STATUS_NOT_FOUND);
                     end
                  end
               end
            endcase
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         fires_ff      <= '0;
         found_ff      <= 1'b0;
         cnt_ff        <= '0;
         elapsed_ff    <= '0;
         prev_raw_ff   <= '0;
         raw_seen_ff   <= 1'b0;
         max_step_ff   <= pes_pkg::MAX_STEP_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         rd_vld_ff     <= rd_vld_in;
         pend_valid_ff <= pend_valid_in;
         fires_ff      <= fires_in;
         found_ff      <= found_in;
         cnt_ff        <= cnt_in;
         elapsed_ff    <= elapsed_in;
         prev_raw_ff   <= prev_raw_in;
         raw_seen_ff   <= raw_seen_in;
         if (csr_valid && csr_ready) begin
            max_step_ff <= csr_data;
         end
         // hold a stalled result, advance on transfer
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rd_slot_ff   <= rd_slot_in;
      best_slot_ff <= best_slot_in;
      best_ff      <= best_in;
      pend_ff      <= pend_in;
      if (emit) begin
         rsp_data_ff <= emit_data;
      end
   end
endmodule
`default_nettype wire

FILE: sv/pes_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module pes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: sv/pes_checker.sv
// Port-level checker for the periodic event scheduler, bound to the top.
// Depends on pes_pkg and periodic_event_scheduler_defines.svh.
`default_nettype none
`include "periodic_event_scheduler_defines.svh"
module pes_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire pes_pkg::rsp_type rsp_data
);
   `PES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `PES_ASSERT_SAME(a_fire_ok, clock, reset, rsp_valid && rsp_data.fired, rsp_data.status == pes_pkg::STATUS_OK)
   `PES_ASSERT_SAME(a_status_last, clock, reset, rsp_valid && !rsp_data.fired, rsp_data.last && (rsp_data.fired_id == 8'd0))
endmodule

bind periodic_event_scheduler pes_checker u_pes_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
`default_nettype wire
